// ===== design/cdu_pkg.sv =====
package cdu_pkg;

  // value widths
  localparam int VAL_W  = 48;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 31;
  localparam int LINK_W = 6;
  localparam int NODE_W = 4;
  localparam int CIDX_W = 2;

  // parameter defaults
  localparam int MAX_LINKS_DEF      = 64;
  localparam int NODES_PER_LINK_DEF = 16;

  // register reset values
  localparam logic [CFG_W-1:0] TIME_STEP_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] CELL_WIDTH_RST = 31'd1966080;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CELL_WIDTH = 2'd1;

  typedef logic signed [VAL_W-1:0] val_t;

  // saturation limits
  localparam val_t WIDE_LIM = 48'sh7FFF_FFFF_FFFF;
  localparam val_t I32_MAX  = 48'sh0000_7FFF_FFFF;
  localparam val_t I32_MIN  = -48'sh0000_8000_0000;

  // response of a serial arithmetic unit
  typedef struct packed {
    logic done;
    val_t value;
  } unit_rsp_t;

  // clamp a grown sum to the working range
  function automatic val_t sat_w(input logic signed [VAL_W+2:0] v);
    logic signed [VAL_W+2:0] lim;
    lim = {3'b000, WIDE_LIM};
    if (v > lim) return WIDE_LIM;
    else if (v < -lim) return -WIDE_LIM;
    else return v[VAL_W-1:0];
  endfunction

  // clamp to the signed 32-bit range
  function automatic val_t sat32(input val_t v);
    if (v > I32_MAX) return I32_MAX;
    else if (v < I32_MIN) return I32_MIN;
    else return v;
  endfunction

  // magnitude of a working value (never the most negative code)
  function automatic logic [VAL_W-2:0] mag(input val_t v);
    val_t t;
    t = v[VAL_W-1] ? -v : v;
    return t[VAL_W-2:0];
  endfunction

endpackage

// ===== design/cdu_ram.sv =====
module cdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cdu_mul.sv =====
module cdu_mul import cdu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  val_t      a,
  input  val_t      b,
  output unit_rsp_t rsp
);

  localparam int MAG_W  = VAL_W - 1;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SHR_W  = PROD_W - FRAC_W;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t           state;
  logic [MAG_W-1:0]  mcand;
  logic [PROD_W-1:0] prod;
  logic              neg;
  logic [5:0]        cnt;

  logic [MAG_W:0]    sum;
  logic [SHR_W:0]    rnd;
  logic [MAG_W-1:0]  rmag;
  val_t              rval;

  // one multiplier bit per cycle: add, then shift right
  always_comb begin
    sum = {1'b0, prod[PROD_W-1:MAG_W]} + (prod[0] ? {1'b0, mcand} : '0);
  end

  // drop the fraction with rounding, clamp, apply sign
  always_comb begin
    rnd  = {1'b0, prod[PROD_W-1:FRAC_W]} + (SHR_W+1)'(prod[FRAC_W-1]);
    rmag = (rnd > (SHR_W+1)'(WIDE_LIM)) ? WIDE_LIM[MAG_W-1:0] : rnd[MAG_W-1:0];
    rval = neg ? -val_t'({1'b0, rmag}) : val_t'({1'b0, rmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= M_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            mcand <= mag(a);
            prod  <= {{MAG_W{1'b0}}, mag(b)};
            neg   <= a[VAL_W-1] ^ b[VAL_W-1];
            cnt   <= 6'(MAG_W - 1);
            state <= M_RUN;
          end
        end
        M_RUN: begin
          prod <= {sum, prod[MAG_W-1:1]};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          rsp.value <= rval;
          rsp.done  <= 1'b1;
          state     <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cdu_div.sv =====
module cdu_div import cdu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  val_t      a,
  input  val_t      b,
  output unit_rsp_t rsp
);

  localparam int MAG_W = VAL_W - 1;
  localparam int NUM_W = VAL_W + FRAC_W;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          state;
  logic [MAG_W-1:0] dvsr;
  logic [VAL_W-1:0] rem;
  logic [NUM_W-1:0] nq;
  logic             neg;
  logic             zdiv;
  logic             azero;
  logic             aneg;
  logic [5:0]       cnt;

  logic [VAL_W-1:0] trial;
  logic             ge;
  logic [MAG_W-1:0] qmag;
  val_t             rval;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial = {rem[VAL_W-2:0], nq[NUM_W-1]};
    ge    = trial >= {1'b0, dvsr};
  end

  // clamp quotient, handle a zero divisor
  always_comb begin
    qmag = (|nq[NUM_W-1:MAG_W]) ? WIDE_LIM[MAG_W-1:0] : nq[MAG_W-1:0];
    if (zdiv) begin
      rval = azero ? '0 : (aneg ? -WIDE_LIM : WIDE_LIM);
    end else begin
      rval = neg ? -val_t'({1'b0, qmag}) : val_t'({1'b0, qmag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            dvsr  <= mag(b);
            rem   <= '0;
            nq    <= {1'b0, mag(a), {FRAC_W{1'b0}}} + NUM_W'(mag(b) >> 1);
            neg   <= a[VAL_W-1] ^ b[VAL_W-1];
            zdiv  <= (b == '0);
            azero <= (a == '0);
            aneg  <= a[VAL_W-1];
            cnt   <= 6'(NUM_W - 1);
            state <= (b == '0) ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          rem  <= ge ? (trial - {1'b0, dvsr}) : trial;
          nq   <= {nq[NUM_W-2:0], ge};
          cnt  <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          rsp.value <= rval;
          rsp.done  <= 1'b1;
          state     <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/cdu_sqrt.sv =====
module cdu_sqrt import cdu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  val_t      a,
  output unit_rsp_t rsp
);

  localparam int OP_W   = VAL_W + FRAC_W;
  localparam int ROOT_W = OP_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  typedef enum logic [1:0] {Q_IDLE, Q_RUN, Q_FIN} qstate_t;

  qstate_t           state;
  logic [OP_W-1:0]   op;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [4:0]        cnt;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // two operand bits in, one root bit out per cycle
  always_comb begin
    shifted = {rem[REM_W-3:0], op[OP_W-1:OP_W-2]};
    trial   = {root, 2'b01};
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= Q_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        Q_IDLE: begin
          if (start) begin
            op    <= (a[VAL_W-1] || a == '0) ? '0 :
                     {1'b0, a[VAL_W-2:0], {FRAC_W{1'b0}}};
            rem   <= '0;
            root  <= '0;
            cnt   <= 5'(ROOT_W - 1);
            state <= Q_RUN;
          end
        end
        Q_RUN: begin
          op   <= {op[OP_W-3:0], 2'b00};
          rem  <= ge ? (shifted - trial) : shifted;
          root <= {root[ROOT_W-2:0], ge};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= Q_FIN;
          end
        end
        Q_FIN: begin
          rsp.value <= val_t'({{(VAL_W-ROOT_W){1'b0}}, root});
          rsp.done  <= 1'b1;
          state     <= Q_IDLE;
        end
        default: state <= Q_IDLE;
      endcase
    end
  end

endmodule

// ===== design/channel_depth_update.sv =====
// A rectangular section (zero side slope) runs a shorter step sequence than a
//   trapezoid, and a zero divisor ends a division early.
// Throughput: one item in work at a time; the next is taken in the cycle after
//   the result is registered. Steps run in turn on the multiply, divide and root units.
// Reset (rst, synchronous): registers return to defaults and a clearing pass
//   zeroes all MAX_LINKS*NODES_PER_LINK table entries, one a cycle, before the first item.
module channel_depth_update import cdu_pkg::*; #(
  parameter int MAX_LINKS      = MAX_LINKS_DEF,
  parameter int NODES_PER_LINK = NODES_PER_LINK_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [LINK_W-1:0]        link_index,
  input  logic [NODE_W-1:0]        node_index,
  input  logic [30:0]              side_slope,
  input  logic [30:0]              bank_depth,
  input  logic [30:0]              bottom_width,
  input  logic signed [31:0]       inflow_rate,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       depth_change,
  output logic signed [31:0]       new_depth,
  output logic                     step_error
);

  localparam int TABLE_SIZE = MAX_LINKS * NODES_PER_LINK;
  localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int IDX_W      = ADDR_W + LINK_W + NODE_W;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_RUN, S_WAIT, S_DONE} state_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_SC2, OP_SC4, OP_SAT32, OP_MUL, OP_DIV, OP_SQRT
  } op_t;

  typedef enum logic [4:0] {
    R_Q, R_DT, R_W, R_Z, R_DEP, R_WID, R_H, R_QDT, R_TWOZ, R_FULL,
    R_T, R_U, R_ZD, R_TOPW, R_HN, R_DH, R_OVER, R_MW
  } reg_t;

  typedef enum logic [5:0] {
    ST_QDT, ST_R_WW, ST_R_DH, ST_TWOZ, ST_ZD0, ST_ZD1, ST_FULL,
    ST_A_WF, ST_A_DH, ST_A_HN0, ST_A_HN1,
    ST_A_D0, ST_A_D1, ST_A_D2, ST_A_D3, ST_A_D4, ST_A_D5, ST_A_D6, ST_A_D7, ST_A_D8,
    ST_B_ZH, ST_B_1, ST_B_2, ST_B_3, ST_B_4, ST_B_5, ST_B_6, ST_B_7,
    ST_RT0, ST_RT1, ST_RT2, ST_B_HN0, ST_B_HN1,
    ST_C_0, ST_C_1, ST_C_2, ST_C_3, ST_C_4, ST_C_5, ST_C_6, ST_C_7
  } step_t;

  state_t            state;
  step_t             step;
  logic [ADDR_W-1:0] clr_addr;
  logic [CFG_W-1:0]  time_step;
  logic [CFG_W-1:0]  cell_width;
  logic              unit_start;
  logic              above;
  logic              err;
  logic [ADDR_W-1:0] idx_r;
  logic              inside_r;

  // working registers
  val_t q, z, dep, wid, h, qdt, twoz, full, t, u, zd, topw, hn, dh, over, mw;
  val_t dt, w;

  // step decode
  op_t   op;
  reg_t  sa, sb, dst;
  step_t nxt;
  logic  fin;
  logic  slow;

  val_t      opa, opb, alu_val, res;
  unit_rsp_t mul_rsp, div_rsp, sqrt_rsp;
  logic      any_done;
  logic      commit;
  step_t     nxt_br;
  logic      fin_br;

  logic [IDX_W-1:0]  idx_full;
  logic              in_table;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;
  logic              tbl_write;
  val_t              dh_out;

  assign dt = val_t'({{(VAL_W-CFG_W){1'b0}}, time_step});
  assign w  = val_t'({{(VAL_W-CFG_W){1'b0}}, cell_width});

  // table address of the offered item
  always_comb begin
    idx_full = IDX_W'(link_index) * IDX_W'(NODES_PER_LINK) + IDX_W'(node_index);
    in_table = (32'(node_index) < NODES_PER_LINK) && (32'(idx_full) < TABLE_SIZE);
  end

  // step program: operation, operands, destination, successor
  always_comb begin
    op  = OP_ADD;
    sa  = R_T;
    sb  = R_T;
    dst = R_T;
    nxt = ST_QDT;
    fin = 1'b0;
    case (step)
      ST_QDT:   begin op = OP_MUL;  sa = R_Q;    sb = R_DT;   dst = R_QDT;  nxt = ST_TWOZ;  end
      ST_R_WW:  begin op = OP_MUL;  sa = R_W;    sb = R_WID;  dst = R_T;    nxt = ST_R_DH;  end
      ST_R_DH:  begin op = OP_DIV;  sa = R_QDT;  sb = R_T;    dst = R_DH;   fin = 1'b1;     end
      ST_TWOZ:  begin op = OP_SC2;  sa = R_Z;                 dst = R_TWOZ; nxt = ST_ZD0;   end
      ST_ZD0:   begin op = OP_MUL;  sa = R_Z;    sb = R_DEP;  dst = R_T;    nxt = ST_ZD1;   end
      ST_ZD1:   begin op = OP_SC2;  sa = R_T;                 dst = R_T;    nxt = ST_FULL;  end
      ST_FULL:  begin op = OP_ADD;  sa = R_WID;  sb = R_T;    dst = R_FULL; nxt = ST_B_ZH;  end
      ST_A_WF:  begin op = OP_MUL;  sa = R_W;    sb = R_FULL; dst = R_T;    nxt = ST_A_DH;  end
      ST_A_DH:  begin op = OP_DIV;  sa = R_QDT;  sb = R_T;    dst = R_DH;   nxt = ST_A_HN0; end
      ST_A_HN0: begin op = OP_ADD;  sa = R_H;    sb = R_DH;   dst = R_HN;   nxt = ST_A_HN1; end
      ST_A_HN1: begin op = OP_SAT32; sa = R_HN;               dst = R_HN;   fin = 1'b1;     end
      ST_A_D0:  begin op = OP_SUB;  sa = R_DEP;  sb = R_HN;   dst = R_T;    nxt = ST_A_D1;  end
      ST_A_D1:  begin op = OP_MUL;  sa = R_Z;    sb = R_T;    dst = R_ZD;   nxt = ST_A_D2;  end
      ST_A_D2:  begin op = OP_MUL;  sa = R_Z;    sb = R_HN;   dst = R_T;    nxt = ST_A_D3;  end
      ST_A_D3:  begin op = OP_SC2;  sa = R_T;                 dst = R_T;    nxt = ST_A_D4;  end
      ST_A_D4:  begin op = OP_ADD;  sa = R_T;    sb = R_WID;  dst = R_TOPW; nxt = ST_A_D5;  end
      ST_A_D5:  begin op = OP_MUL;  sa = R_TOPW; sb = R_TOPW; dst = R_T;    nxt = ST_A_D6;  end
      ST_A_D6:  begin op = OP_MUL;  sa = R_ZD;   sb = R_ZD;   dst = R_U;    nxt = ST_A_D7;  end
      ST_A_D7:  begin op = OP_SC4;  sa = R_U;                 dst = R_U;    nxt = ST_A_D8;  end
      ST_A_D8:  begin op = OP_ADD;  sa = R_T;    sb = R_U;    dst = R_T;    nxt = ST_RT0;   end
      ST_B_ZH:  begin op = OP_MUL;  sa = R_Z;    sb = R_H;    dst = R_T;    nxt = ST_B_1;   end
      ST_B_1:   begin op = OP_SC2;  sa = R_T;                 dst = R_T;    nxt = ST_B_2;   end
      ST_B_2:   begin op = OP_ADD;  sa = R_T;    sb = R_WID;  dst = R_TOPW; nxt = ST_B_3;   end
      ST_B_3:   begin op = OP_MUL;  sa = R_Z;    sb = R_QDT;  dst = R_T;    nxt = ST_B_4;   end
      ST_B_4:   begin op = OP_SC4;  sa = R_T;                 dst = R_T;    nxt = ST_B_5;   end
      ST_B_5:   begin op = OP_DIV;  sa = R_T;    sb = R_W;    dst = R_U;    nxt = ST_B_6;   end
      ST_B_6:   begin op = OP_MUL;  sa = R_TOPW; sb = R_TOPW; dst = R_T;    nxt = ST_B_7;   end
      ST_B_7:   begin op = OP_ADD;  sa = R_T;    sb = R_U;    dst = R_T;    nxt = ST_RT0;   end
      ST_RT0:   begin op = OP_SQRT; sa = R_T;                 dst = R_U;    nxt = ST_RT1;   end
      ST_RT1:   begin op = OP_SUB;  sa = R_U;    sb = R_TOPW; dst = R_T;    nxt = ST_RT2;   end
      ST_RT2:   begin op = OP_DIV;  sa = R_T;    sb = R_TWOZ; dst = R_DH;   nxt = ST_B_HN0; end
      ST_B_HN0: begin op = OP_ADD;  sa = R_H;    sb = R_DH;   dst = R_HN;   nxt = ST_B_HN1; end
      ST_B_HN1: begin op = OP_SAT32; sa = R_HN;               dst = R_HN;   fin = 1'b1;     end
      ST_C_0:   begin op = OP_SUB;  sa = R_HN;   sb = R_DEP;  dst = R_OVER; nxt = ST_C_1;   end
      ST_C_1:   begin op = OP_MUL;  sa = R_Z;    sb = R_HN;   dst = R_T;    nxt = ST_C_2;   end
      ST_C_2:   begin op = OP_ADD;  sa = R_WID;  sb = R_T;    dst = R_MW;   nxt = ST_C_3;   end
      ST_C_3:   begin op = OP_MUL;  sa = R_Z;    sb = R_DEP;  dst = R_T;    nxt = ST_C_4;   end
      ST_C_4:   begin op = OP_ADD;  sa = R_MW;   sb = R_T;    dst = R_MW;   nxt = ST_C_5;   end
      ST_C_5:   begin op = OP_MUL;  sa = R_OVER; sb = R_MW;   dst = R_T;    nxt = ST_C_6;   end
      ST_C_6:   begin op = OP_DIV;  sa = R_T;    sb = R_FULL; dst = R_T;    nxt = ST_C_7;   end
      ST_C_7:   begin op = OP_SUB;  sa = R_T;    sb = R_OVER; dst = R_DH;   fin = 1'b1;     end
      default:  begin fin = 1'b1; end
    endcase
  end

  // operand select
  function automatic val_t pick(input reg_t s, input val_t vq, vdt, vw, vz, vdep, vwid,
                                vh, vqdt, vtwoz, vfull, vt, vu, vzd, vtopw, vhn, vdh,
                                vover, vmw);
    case (s)
      R_Q:     return vq;
      R_DT:    return vdt;
      R_W:     return vw;
      R_Z:     return vz;
      R_DEP:   return vdep;
      R_WID:   return vwid;
      R_H:     return vh;
      R_QDT:   return vqdt;
      R_TWOZ:  return vtwoz;
      R_FULL:  return vfull;
      R_T:     return vt;
      R_U:     return vu;
      R_ZD:    return vzd;
      R_TOPW:  return vtopw;
      R_HN:    return vhn;
      R_DH:    return vdh;
      R_OVER:  return vover;
      R_MW:    return vmw;
      default: return vt;
    endcase
  endfunction

  always_comb begin
    opa = pick(sa, q, dt, w, z, dep, wid, h, qdt, twoz, full, t, u, zd, topw, hn, dh,
               over, mw);
    opb = pick(sb, q, dt, w, z, dep, wid, h, qdt, twoz, full, t, u, zd, topw, hn, dh,
               over, mw);
  end

  // combinational operations
  always_comb begin
    logic signed [VAL_W+2:0] ax;
    logic signed [VAL_W+2:0] bx;
    ax = {{3{opa[VAL_W-1]}}, opa};
    bx = {{3{opb[VAL_W-1]}}, opb};
    case (op)
      OP_ADD:   alu_val = sat_w(ax + bx);
      OP_SUB:   alu_val = sat_w(ax - bx);
      OP_SC2:   alu_val = sat_w(ax <<< 1);
      OP_SC4:   alu_val = sat_w(ax <<< 2);
      OP_SAT32: alu_val = sat32(opa);
      default:  alu_val = '0;
    endcase
  end

  // serial units
  cdu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start && op == OP_MUL),
    .a     (opa),
    .b     (opb),
    .rsp   (mul_rsp)
  );

  cdu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start && op == OP_DIV),
    .a     (opa),
    .b     (opb),
    .rsp   (div_rsp)
  );

  cdu_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start && op == OP_SQRT),
    .a     (opa),
    .rsp   (sqrt_rsp)
  );

  // result of the current step
  always_comb begin
    slow     = op inside {OP_MUL, OP_DIV, OP_SQRT};
    any_done = mul_rsp.done | div_rsp.done | sqrt_rsp.done;
    case (op)
      OP_MUL:  res = mul_rsp.value;
      OP_DIV:  res = div_rsp.value;
      OP_SQRT: res = sqrt_rsp.value;
      default: res = alu_val;
    endcase
    commit = (state == S_RUN && !slow) || (state == S_WAIT && any_done);
  end

  // data-dependent branches
  always_comb begin
    nxt_br = nxt;
    fin_br = fin;
    case (step)
      ST_QDT:   if (z == '0) nxt_br = ST_R_WW;
      ST_FULL:  if (h > dep) nxt_br = ST_A_WF;
      ST_A_HN1: if (res < dep) fin_br = 1'b0;
      ST_B_7:   if (res[VAL_W-1]) fin_br = 1'b1;
      ST_RT2:   if (above) fin_br = 1'b1;
      ST_B_HN1: if (res > dep) fin_br = 1'b0;
      default:  nxt_br = nxt;
    endcase
    if (step == ST_A_HN1) nxt_br = ST_A_D0;
    if (step == ST_B_HN1) nxt_br = ST_C_0;
  end

  // table write on completion; a clearing pass after reset
  assign tbl_write = inside_r && !err && (z != '0);
  assign dh_out    = sat32(dh);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_DONE && (!out_valid || !out_stall) && tbl_write) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = hn[31:0];
    end
  end

  cdu_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_full[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      unit_start <= 1'b0;
      time_step  <= TIME_STEP_RST;
      cell_width <= CELL_WIDTH_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:  time_step  <= cfg_data;
          CFG_CELL_WIDTH: cell_width <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      // kick the serial unit of a slow step
      unit_start <= (state == S_RUN) && slow;

      if (commit) begin
        case (dst)
          R_QDT:   qdt  <= res;
          R_TWOZ:  twoz <= res;
          R_FULL:  full <= res;
          R_T:     t    <= res;
          R_U:     u    <= res;
          R_ZD:    zd   <= res;
          R_TOPW:  topw <= res;
          R_HN:    hn   <= res;
          R_DH:    dh   <= res;
          R_OVER:  over <= res;
          R_MW:    mw   <= res;
          default: ;
        endcase
        if (step == ST_FULL) above <= (h > dep);
        if (step == ST_B_7 && res[VAL_W-1]) err <= 1'b1;
        if (fin_br) begin
          state <= S_DONE;
        end else begin
          step  <= nxt_br;
          state <= S_RUN;
        end
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            q        <= val_t'({{(VAL_W-32){inflow_rate[31]}}, inflow_rate});
            z        <= val_t'({{(VAL_W-31){1'b0}}, side_slope});
            dep      <= val_t'({{(VAL_W-31){1'b0}}, bank_depth});
            wid      <= val_t'({{(VAL_W-31){1'b0}}, bottom_width});
            idx_r    <= idx_full[ADDR_W-1:0];
            inside_r <= in_table;
            state    <= S_READ;
          end
        end
        S_READ: begin
          h     <= inside_r ? val_t'({{(VAL_W-32){ram_rdata[31]}}, ram_rdata}) : '0;
          hn    <= inside_r ? val_t'({{(VAL_W-32){ram_rdata[31]}}, ram_rdata}) : '0;
          dh    <= '0;
          err   <= 1'b0;
          above <= 1'b0;
          step  <= ST_QDT;
          state <= S_RUN;
        end
        S_RUN: begin
          if (slow) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: ;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            depth_change <= dh_out[31:0];
            new_depth    <= hn[31:0];
            step_error   <= err;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // only one serial unit answers at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_rsp.done, div_rsp.done, sqrt_rsp.done}))
    else $error("two serial units finished together");

  // a unit answers only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    (mul_rsp.done || div_rsp.done || sqrt_rsp.done) |-> state == S_WAIT)
    else $error("serial unit finished outside a wait");

  // the stored depth is always within 32 bits
  a_hn_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> (hn <= I32_MAX && hn >= I32_MIN))
    else $error("new depth outside 32-bit range");

  // an error item leaves the depth as it was
  a_err_keeps_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && err) |-> (hn == h && dh == '0))
    else $error("error item changed the depth");

endmodule
